FILE: rtl/core/tpas_pkg.sv
// Shared types and constants for the TLB purge address sequencer.
package tpas_pkg;

  // Default parameter values
  localparam int ADDR_BITS_DEF  = 64;
  localparam int MAX_PURGES_DEF = 64;

  // Configuration space: seven 64-bit registers at 8-byte spacing
  localparam int CFG_ADDR_W = 6;
  localparam logic [63:0] PURGE_MASK_RST = 64'h0000_0001_1555_7000;

  // Leading-one scanner: width of the word and chunk examined per cycle
  localparam int SCAN_W     = 64;
  localparam int SCAN_CHUNK = 16;
  localparam int SCAN_IDX_W = $clog2(SCAN_W);

  // Purge command kinds
  localparam logic [1:0] KIND_LOCAL  = 2'd0;
  localparam logic [1:0] KIND_GLOBAL = 2'd1;
  localparam logic [1:0] KIND_ENTRY  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  typedef enum logic [2:0] {
    REG_PURGE_MASK   = 3'd0,
    REG_GLOBAL_MODE  = 3'd1,
    REG_ENTRY_BASE   = 3'd2,
    REG_OUTER_COUNT  = 3'd3,
    REG_INNER_COUNT  = 3'd4,
    REG_OUTER_STRIDE = 3'd5,
    REG_INNER_STRIDE = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [63:0] purge_mask;
    logic        global_mode;
    logic [63:0] entry_base;
    logic [3:0]  outer_count;
    logic [3:0]  inner_count;
    logic [63:0] outer_stride;
    logic [63:0] inner_stride;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [SCAN_W-1:0] word;
  } scan_req_t;

  typedef struct packed {
    logic                  done;
    logic                  found;
    logic [SCAN_IDX_W-1:0] idx;
  } scan_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SIZE,
    S_SCANX,
    S_SCANM,
    S_SCANL,
    S_ALIGN,
    S_SUMS,
    S_EMPTY,
    S_EMIT
  } state_t;

endpackage

FILE: rtl/core/tpas_cfg.sv
// APB-style configuration register file for the purge sequencer.
module tpas_cfg
  import tpas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_idx_t idx;
  logic     wr_en;

  assign idx    = cfg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.purge_mask   <= PURGE_MASK_RST;
      cfg_r.global_mode  <= 1'b0;
      cfg_r.entry_base   <= '0;
      cfg_r.outer_count  <= 4'd1;
      cfg_r.inner_count  <= 4'd1;
      cfg_r.outer_stride <= '0;
      cfg_r.inner_stride <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PURGE_MASK:   cfg_r.purge_mask   <= pwdata;
        REG_GLOBAL_MODE:  cfg_r.global_mode  <= pwdata[0];
        REG_ENTRY_BASE:   cfg_r.entry_base   <= pwdata;
        REG_OUTER_COUNT:  cfg_r.outer_count  <= pwdata[3:0];
        REG_INNER_COUNT:  cfg_r.inner_count  <= pwdata[3:0];
        REG_OUTER_STRIDE: cfg_r.outer_stride <= pwdata;
        REG_INNER_STRIDE: cfg_r.inner_stride <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_PURGE_MASK:   prdata = cfg_r.purge_mask;
      REG_GLOBAL_MODE:  prdata = {63'd0, cfg_r.global_mode};
      REG_ENTRY_BASE:   prdata = cfg_r.entry_base;
      REG_OUTER_COUNT:  prdata = {60'd0, cfg_r.outer_count};
      REG_INNER_COUNT:  prdata = {60'd0, cfg_r.inner_count};
      REG_OUTER_STRIDE: prdata = cfg_r.outer_stride;
      REG_INNER_STRIDE: prdata = cfg_r.inner_stride;
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/tpas_bitscan.sv
// Multi-cycle leading-one finder: one chunk of the word per cycle, top down.
module tpas_bitscan
  import tpas_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  scan_req_t req,
  output scan_rsp_t rsp
);

  localparam int NCHUNK  = SCAN_W / SCAN_CHUNK;
  localparam int CNT_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int CHIDX_W = $clog2(SCAN_CHUNK);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SCAN_W-1:0] word_r, word_nxt;
  logic [SCAN_CHUNK-1:0] chunk;
  logic [CHIDX_W-1:0]    sub_idx;
  logic                  chunk_hit;

  assign chunk     = word_r[cnt_r*SCAN_CHUNK +: SCAN_CHUNK];
  assign chunk_hit = |chunk;

  // Priority encode the current chunk (highest set bit wins)
  always_comb begin
    sub_idx = '0;
    for (int k = 0; k < SCAN_CHUNK; k++) begin
      if (chunk[k]) sub_idx = CHIDX_W'(k);
    end
  end

  // Step control and result
  always_comb begin
    rsp.done  = busy_r & (chunk_hit | (cnt_r == '0));
    rsp.found = busy_r & chunk_hit;
    rsp.idx   = chunk_hit ? SCAN_IDX_W'({cnt_r, sub_idx}) : '0;
    busy_nxt  = busy_r & ~rsp.done;
    cnt_nxt   = cnt_r - 1'b1;
    word_nxt  = word_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NCHUNK - 1);
      word_nxt = req.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    word_r <= word_nxt;
  end

endmodule

FILE: rtl/core/tlb_purge_address_sequencer.sv
// Top level: request sequencer with one shared adder/comparator and a leading-one scanner.
//
// Each request word is turned into a run of purge command words, one per
// cycle while the output side takes them, at most MAX_PURGES per request.
// A range request goes through accept and size arithmetic (S_IDLE, S_DIFF,
// S_SIZE), then up to three passes of the leading-one scanner (size exponent,
// highest mask bit, lowest allowed size at or above the exponent), alignment,
// then one purge per cycle while the output side takes them. An entry-walk
// request goes through set-up (S_IDLE, S_SUMS), then one purge per cycle while
// the output takes them; an empty walk gives one marker word. The input side is not
// ready until the last word of a request has entered the output register;
// the output register holds a word while the next request is accepted.
// Configuration may be written only while the block is idle.
module tlb_purge_address_sequencer
  import tpas_pkg::*;
#(
  parameter int MAX_PURGES = MAX_PURGES_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [63:0]           in_range_start,
  input  logic [63:0]           in_range_end,
  // purge command channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_purge_kind,
  output logic [63:0]           out_purge_addr,
  output logic [7:0]            out_size_code,
  output logic                  out_truncated,
  output logic                  out_last
);

  localparam int CW = $clog2(MAX_PURGES + 1);
  localparam logic [63:0] AMASK   = {64{1'b1}} >> (64 - ADDR_BITS);
  localparam logic [64:0] AMASK65 = {1'b0, AMASK};
  localparam logic [63:0] PAGE_ROUND = 64'hfff;

  cfg_t      cfg;
  scan_req_t scan_req;
  scan_rsp_t scan_rsp;

  tpas_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpas_bitscan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scan_req),
    .rsp   (scan_rsp)
  );

  state_t state_r, state_nxt;

  // working registers
  logic [63:0] start_r, start_nxt;
  logic [63:0] end_r, end_nxt;
  logic [63:0] tmp_r, tmp_nxt;       // size, then inner+outer stride
  logic [63:0] a_r, a_nxt;
  logic [63:0] step_r, step_nxt;
  logic [5:0]  nb0_r, nb0_nxt;
  logic [5:0]  nb_r, nb_nxt;
  logic [3:0]  i_r, i_nxt;
  logic [3:0]  j_r, j_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        in_req_type_r, in_req_type_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [63:0] oaddr_r, oaddr_nxt;
  logic [7:0]  code_r, code_nxt;
  logic        trunc_r, trunc_nxt;
  logic        last_r, last_nxt;

  // shared adder
  logic [63:0] add_a, add_b;
  logic        add_ci;
  logic [64:0] add_sum;
  logic        add_ovf, add_ge_end;

  logic        slot_free;
  logic [CW-1:0] cnt_inc;
  logic        cap_hit;
  logic        grid_end;
  logic        j_end;
  logic [63:0] mask_hi;
  logic [63:0] mask_rev;
  logic [1:0]  range_kind;

  assign add_sum    = {1'b0, add_a} + {1'b0, add_b} + {64'd0, add_ci};
  assign add_ovf    = |(add_sum & ~AMASK65);
  assign add_ge_end = (add_sum[63:0] >= end_r);

  assign slot_free  = ~out_valid_r | out_ready;
  assign cnt_inc    = cnt_r + 1'b1;
  assign cap_hit    = (cnt_inc == CW'(MAX_PURGES));
  assign j_end      = (j_r == cfg.inner_count - 4'd1);
  assign grid_end   = j_end & (i_r == cfg.outer_count - 4'd1);
  assign range_kind = cfg.global_mode ? KIND_GLOBAL : KIND_LOCAL;

  // mask bits at or above the size exponent, bit-reversed for the scanner
  assign mask_hi = cfg.purge_mask & ({64{1'b1}} << nb0_r);
  always_comb begin
    for (int k = 0; k < 64; k++) mask_rev[k] = mask_hi[63-k];
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_purge_kind = kind_r;
  assign out_purge_addr = oaddr_r;
  assign out_size_code  = code_r;
  assign out_truncated  = trunc_r;
  assign out_last       = last_r;

  // Sequencer: next state, adder operands and register updates
  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    tmp_nxt       = tmp_r;
    a_nxt         = a_r;
    step_nxt      = step_r;
    nb0_nxt       = nb0_r;
    nb_nxt        = nb_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    kind_nxt      = kind_r;
    oaddr_nxt     = oaddr_r;
    code_nxt      = code_r;
    trunc_nxt     = trunc_r;
    last_nxt      = last_r;
    add_a         = a_r;
    add_b         = step_r;
    add_ci        = 1'b0;
    scan_req.start = 1'b0;
    scan_req.word  = tmp_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          start_nxt = in_range_start & AMASK;
          end_nxt   = in_range_end & AMASK;
          cnt_nxt   = '0;
          i_nxt     = '0;
          j_nxt     = '0;
          if (!in_req_type) begin
            state_nxt = S_DIFF;
          end else if (cfg.outer_count == 4'd0 || cfg.inner_count == 4'd0) begin
            state_nxt = S_EMPTY;
          end else begin
            state_nxt = S_SUMS;
          end
        end
      end

      // size = end - start
      S_DIFF: begin
        add_a     = end_r;
        add_b     = ~start_r;
        add_ci    = 1'b1;
        tmp_nxt   = add_sum[63:0] & AMASK;
        state_nxt = S_SIZE;
      end

      // round up by a page and start the exponent scan
      S_SIZE: begin
        add_a          = tmp_r;
        add_b          = PAGE_ROUND;
        scan_req.start = 1'b1;
        scan_req.word  = add_sum[63:0] & AMASK;
        state_nxt      = S_SCANX;
      end

      S_SCANX: begin
        if (scan_rsp.done) begin
          nb0_nxt        = scan_rsp.idx;
          scan_req.start = 1'b1;
          scan_req.word  = cfg.purge_mask;
          state_nxt      = S_SCANM;
        end
      end

      // highest mask bit known; look for the lowest allowed size >= exponent, else use the highest mask bit
      S_SCANM: begin
        if (scan_rsp.done) begin
          if (mask_hi == '0) begin
            nb_nxt    = scan_rsp.idx;
            state_nxt = S_ALIGN;
          end else begin
            scan_req.start = 1'b1;
            scan_req.word  = mask_rev;
            state_nxt      = S_SCANL;
          end
        end
      end

      S_SCANL: begin
        if (scan_rsp.done) begin
          nb_nxt    = ~scan_rsp.idx;
          state_nxt = S_ALIGN;
        end
      end

      S_ALIGN: begin
        step_nxt  = 64'd1 << nb_r;
        a_nxt     = start_r & ({64{1'b1}} << nb_r);
        state_nxt = S_EMIT;
      end

      // entry walk: precompute the stride after a full inner loop
      S_SUMS: begin
        add_a     = cfg.inner_stride;
        add_b     = cfg.outer_stride;
        tmp_nxt   = add_sum[63:0];
        a_nxt     = cfg.entry_base & AMASK;
        state_nxt = S_EMIT;
      end

      S_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_NONE;
          oaddr_nxt     = '0;
          code_nxt      = '0;
          trunc_nxt     = 1'b0;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_EMIT: begin
        if (in_req_type_r) begin
          add_b = j_end ? tmp_r : cfg.inner_stride;
        end
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          oaddr_nxt     = a_r;
          cnt_nxt       = cnt_inc;
          a_nxt         = add_sum[63:0] & AMASK;
          if (!in_req_type_r) begin
            kind_nxt  = range_kind;
            code_nxt  = {nb_r, 2'b00};
            last_nxt  = add_ovf | add_ge_end | cap_hit;
            trunc_nxt = ~(add_ovf | add_ge_end) & cap_hit;
          end else begin
            kind_nxt  = KIND_ENTRY;
            code_nxt  = '0;
            last_nxt  = grid_end | cap_hit;
            trunc_nxt = ~grid_end & cap_hit;
            if (j_end) begin
              j_nxt = '0;
              i_nxt = i_r + 4'd1;
            end else begin
              j_nxt = j_r + 4'd1;
            end
          end
          if (last_nxt) state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // request type held for the whole run
  assign in_req_type_nxt = (state_r == S_IDLE && in_valid) ? in_req_type : in_req_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_req_type_r <= in_req_type_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
    tmp_r   <= tmp_nxt;
    a_r     <= a_nxt;
    step_r  <= step_nxt;
    nb0_r   <= nb0_nxt;
    nb_r    <= nb_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    cnt_r   <= cnt_nxt;
    kind_r  <= kind_nxt;
    oaddr_r <= oaddr_nxt;
    code_r  <= code_nxt;
    trunc_r <= trunc_nxt;
    last_r  <= last_nxt;
  end

endmodule

FILE: rtl/core/tpas_checker.sv
// Port-level assertions for the purge sequencer, bound to the top level.
module tpas_checker
  import tpas_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_purge_kind,
  input logic [63:0] out_purge_addr,
  input logic [7:0]  out_size_code,
  input logic        out_truncated,
  input logic        out_last
);

  // a stalled command word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_purge_addr)
      && $stable(out_last))
    else $error("stalled purge word changed");

  // the truncation flag only marks the closing word of a run
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_last)
    else $error("truncated set on a non-final word");

  // the empty marker is a lone, clean word
  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_purge_kind == KIND_NONE |->
      out_last && !out_truncated && out_purge_addr == 64'd0 && out_size_code == 8'd0)
    else $error("malformed empty marker");

  // size codes are multiples of four: range sizes are page bits times four, entry sizes zero
  a_size_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_purge_kind == KIND_ENTRY && out_size_code == 8'd0)
      || (out_purge_kind == KIND_NONE)
      || (out_size_code[1:0] == 2'b00))
    else $error("bad size code");

endmodule

bind tlb_purge_address_sequencer tpas_checker u_tpas_checker (.*);
